[src/gbacc_pkg.sv]
// Shared types, constants and GF(2^128) helpers for the GHASH block accumulator.
`timescale 1ns / 1ps

package gbacc_pkg;

  // Default digit width of the serial multiplier.
  localparam int DIGIT_BITS_DEF = 4;

  // Field widths.
  localparam int BLK_W     = 128;
  localparam int HALF_W    = 64;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = CFG_IDX_W'(1);

  // Reduction term for x^128 + x^7 + x^2 + x + 1 in the bit-reflected convention.
  localparam logic [BLK_W-1:0] REDUCE_POLY = {8'hE1, 120'h0};

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_BUILD,
    ST_IDLE,
    ST_MULT,
    ST_HOLD
  } state_t;

  // Status returned by the digit-serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Multiply by x: shift towards higher coefficients and fold the bit that falls off.
  function automatic logic [BLK_W-1:0] times_x(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ REDUCE_POLY;
    end
    return r;
  endfunction

endpackage

[src/gbacc_digit_mul.sv]
// Digit-serial GF(2^128) multiplier: one digit of the operand per cycle, highest digit first.
`timescale 1ns / 1ps

module gbacc_digit_mul #(
  parameter int DIGIT_BITS = gbacc_pkg::DIGIT_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [gbacc_pkg::BLK_W-1:0]                 x_in,
  input  logic [DIGIT_BITS-1:0][gbacc_pkg::BLK_W-1:0] pw,
  output gbacc_pkg::mul_stat_t                        stat,
  output logic [gbacc_pkg::BLK_W-1:0]                 product
);

  localparam int NDIG  = (gbacc_pkg::BLK_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SR_W  = NDIG * DIGIT_BITS;
  localparam int PAD   = SR_W - gbacc_pkg::BLK_W;
  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [SR_W-1:0]                 sr_r;
  logic [gbacc_pkg::BLK_W-1:0]     z_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [gbacc_pkg::BLK_W-1:0]     z_shift;
  logic [gbacc_pkg::BLK_W-1:0]     z_nxt;

  // Horner step: scale the partial product by x^DIGIT_BITS, then add the digit multiple.
  // The digit sits at the low end of the shift register, its lowest coefficient highest.
  always_comb begin
    z_shift = z_r;
    for (int s = 0; s < DIGIT_BITS; s++) begin
      z_shift = gbacc_pkg::times_x(z_shift);
    end
    z_nxt = z_shift;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (sr_r[DIGIT_BITS-1-j]) begin
        z_nxt = z_nxt ^ pw[j];
      end
    end
  end

  // Control: busy while the digits are consumed, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NDIG - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the operand is padded at the low end so a partial top digit reads as zero.
  always_ff @(posedge clk) begin
    if (start) begin
      sr_r <= SR_W'(x_in) << PAD;
      z_r  <= '0;
    end else if (busy_r) begin
      sr_r <= sr_r >> DIGIT_BITS;
      z_r  <= z_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = z_r;

endmodule

[src/ghash_block_accumulator_top.sv]
// Top level of the GHASH block accumulator: key registers, table build, accumulator and handshakes.
`timescale 1ns / 1ps

// The block keeps the GHASH accumulator Y and computes Y = (Y xor X) * H for each 128-bit block
// X, returning the new Y. H is written through the configuration port as two 64-bit halves;
// after reset and after every key write the block builds the powers H*x^i that the
// multiplier uses, and takes no block during that time. Setting in_restart clears Y before
// the block is absorbed. The digit-serial multiplier consumes one digit of the block per
// cycle. A result waits in the output register while the next block is already taken in.
module ghash_block_accumulator_top #(
  parameter int DIGIT_BITS = gbacc_pkg::DIGIT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbacc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbacc_pkg::HALF_W-1:0]      cfg_data,
  // Block input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gbacc_pkg::HALF_W-1:0]      in_block_hi,
  input  logic [gbacc_pkg::HALF_W-1:0]      in_block_lo,
  input  logic                              in_restart,
  // Hash output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gbacc_pkg::HALF_W-1:0]      out_hash_hi,
  output logic [gbacc_pkg::HALF_W-1:0]      out_hash_lo
);

  localparam int BLD_W = (DIGIT_BITS > 1) ? $clog2(DIGIT_BITS) : 1;

  gbacc_pkg::state_t                         state_r;
  gbacc_pkg::state_t                         state_nxt;
  logic [gbacc_pkg::HALF_W-1:0]              key_hi_r;
  logic [gbacc_pkg::HALF_W-1:0]              key_lo_r;
  logic [gbacc_pkg::HALF_W-1:0]              key_hi_nxt;
  logic [gbacc_pkg::HALF_W-1:0]              key_lo_nxt;
  logic [gbacc_pkg::BLK_W-1:0]               cur_r;
  logic [BLD_W-1:0]                          bld_cnt_r;
  logic [DIGIT_BITS-1:0][gbacc_pkg::BLK_W-1:0] pw_r;
  logic [gbacc_pkg::BLK_W-1:0]               acc_r;
  logic                                      out_valid_r;
  logic [gbacc_pkg::BLK_W-1:0]               out_hash_r;
  logic                                      cfg_xfer;
  logic                                      in_xfer;
  logic                                      out_free;
  logic                                      load_out_prod;
  logic                                      load_out_acc;
  logic                                      bld_last;
  logic [gbacc_pkg::BLK_W-1:0]               x_in;
  logic [gbacc_pkg::BLK_W-1:0]               product;
  gbacc_pkg::mul_stat_t                      mul_stat;

  assign cfg_xfer = cfg_valid && cfg_ready;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign bld_last = (bld_cnt_r == BLD_W'(DIGIT_BITS - 1));

  // Operand for the multiplier: the block absorbed into the (possibly cleared) accumulator.
  assign x_in = {in_block_hi, in_block_lo} ^ (in_restart ? '0 : acc_r);

  // Register decode for configuration writes; unknown indexes leave the key alone.
  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    unique case (cfg_index)
      gbacc_pkg::REG_KEY_HI: key_hi_nxt = cfg_data;
      gbacc_pkg::REG_KEY_LO: key_lo_nxt = cfg_data;
      default: begin
        key_hi_nxt = key_hi_r;
        key_lo_nxt = key_lo_r;
      end
    endcase
  end

  // Control state machine: next state and handshake outputs.
  always_comb begin
    state_nxt     = state_r;
    cfg_ready     = 1'b0;
    in_ready      = 1'b0;
    load_out_prod = 1'b0;
    load_out_acc  = 1'b0;
    unique case (state_r)
      gbacc_pkg::ST_BUILD: begin
        cfg_ready = 1'b1;
        if (bld_last) begin
          state_nxt = gbacc_pkg::ST_IDLE;
        end
      end
      gbacc_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid && !mul_stat.busy;
        if (in_xfer) begin
          state_nxt = gbacc_pkg::ST_MULT;
        end
      end
      gbacc_pkg::ST_MULT: begin
        if (mul_stat.done) begin
          if (out_free) begin
            load_out_prod = 1'b1;
            state_nxt     = gbacc_pkg::ST_IDLE;
          end else begin
            state_nxt = gbacc_pkg::ST_HOLD;
          end
        end
      end
      gbacc_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out_acc = 1'b1;
          state_nxt    = gbacc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbacc_pkg::ST_BUILD;
    endcase
    // A key write restarts the table build from the new key.
    if (cfg_xfer) begin
      state_nxt = gbacc_pkg::ST_BUILD;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbacc_pkg::ST_BUILD;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      cur_r       <= '0;
      bld_cnt_r   <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Table build: step the key by x once per cycle and store each power.
      if (cfg_xfer) begin
        key_hi_r  <= key_hi_nxt;
        key_lo_r  <= key_lo_nxt;
        cur_r     <= {key_hi_nxt, key_lo_nxt};
        bld_cnt_r <= '0;
      end else if (state_r == gbacc_pkg::ST_BUILD) begin
        cur_r     <= gbacc_pkg::times_x(cur_r);
        bld_cnt_r <= bld_last ? '0 : bld_cnt_r + BLD_W'(1);
      end
      // The accumulator follows every finished multiply.
      if (state_r == gbacc_pkg::ST_MULT && mul_stat.done) begin
        acc_r <= product;
      end
      // Output register valid flag.
      if (load_out_prod || load_out_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Powers of the key and output payload.
  always_ff @(posedge clk) begin
    if (state_r == gbacc_pkg::ST_BUILD && !cfg_xfer) begin
      pw_r[bld_cnt_r] <= cur_r;
    end
    if (load_out_prod) begin
      out_hash_r <= product;
    end else if (load_out_acc) begin
      out_hash_r <= acc_r;
    end
  end

  // Digit-serial multiplier.
  gbacc_digit_mul #(
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer),
    .x_in    (x_in),
    .pw      (pw_r),
    .stat    (mul_stat),
    .product (product)
  );

  assign out_valid   = out_valid_r;
  assign out_hash_hi = out_hash_r[gbacc_pkg::BLK_W-1:gbacc_pkg::HALF_W];
  assign out_hash_lo = out_hash_r[gbacc_pkg::HALF_W-1:0];

endmodule
